### rtl/aws_pkg.sv
// ----------------------------------------------------------------------------
// aws_pkg: shared types and constants for the associative word store
// Holds the request and result word layouts, the status codes, the controller
// state encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aws_pkg;

    localparam int ENTRIES_DEFAULT = 128;
    localparam int ADDR_W          = 32;
    localparam int DATA_W          = 32;
    localparam int STATUS_W        = 2;

    // Request kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_MISALIGNED = 2'd1,
        STAT_FULL       = 2'd2,
        STAT_NOT_FOUND  = 2'd3
    } aws_status_t;

    // One request word.
    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } aws_req_t;

    // One result word.
    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
    } aws_rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } aws_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // capture a new request and restart the scan
        logic scan;    // step the tag scan by one entry
        logic commit;  // apply the write and load the result register
    } aws_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic done;      // the request's outcome is known
        logic out_free;  // the result register can take a new word
    } aws_sts_t;

endpackage

### rtl/aws_ctrl.sv
// ----------------------------------------------------------------------------
// aws_ctrl: request sequencer for the associative word store
// Accepts a request, runs the tag scan until the outcome is known and then
// commits the result once the result register has room.
// ----------------------------------------------------------------------------
module aws_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aws_pkg::aws_sts_t sts,
    output aws_pkg::aws_cmd_t cmd
);

    aws_pkg::aws_state_t state_reg;
    aws_pkg::aws_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aws_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            aws_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = aws_pkg::ST_SCAN;
                end
            end
            aws_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.done) begin
                    if (sts.out_free) begin
                        cmd.commit = 1'b1;
                        state_next = aws_pkg::ST_IDLE;
                    end else begin
                        state_next = aws_pkg::ST_WAIT;
                    end
                end
            end
            aws_pkg::ST_WAIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = aws_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aws_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/aws_dpath.sv
// ----------------------------------------------------------------------------
// aws_dpath: tag/word memory, scan logic and result register
// Entries fill from index zero upward and are never freed, so the fill count
// alone tells which entries are valid.
// ----------------------------------------------------------------------------
module aws_dpath #(
    parameter int ENTRIES = aws_pkg::ENTRIES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  aws_pkg::aws_req_t s_data,
    input  aws_pkg::aws_cmd_t cmd,
    output aws_pkg::aws_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output aws_pkg::aws_rsp_t m_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = aws_pkg::ADDR_W + aws_pkg::DATA_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    // Each entry holds {tag, word}.
    logic [EW-1:0] mem_array [ENTRIES];

    aws_pkg::aws_req_t         req_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             idx_reg;
    logic                      pend_reg;
    logic [IW-1:0]             pend_idx_reg;
    logic [EW-1:0]             rd_entry_reg;
    logic                      hit_reg;
    logic [IW-1:0]             hit_idx_reg;
    logic [aws_pkg::DATA_W-1:0] hit_word_reg;
    logic                      m_valid_reg;
    aws_pkg::aws_rsp_t         m_data_reg;

    logic                      misaligned;
    logic                      can_issue;
    logic                      tag_match;
    logic                      has_room;
    logic                      mem_we;
    logic [IW-1:0]             mem_waddr;
    logic                      count_inc;
    aws_pkg::aws_rsp_t         rsp_next;

    assign misaligned = (req_reg.address[1:0] != 2'b00);
    assign can_issue  = cmd.scan && !misaligned && !hit_reg && (idx_reg != count_reg);
    assign tag_match  = pend_reg && !hit_reg
                        && (rd_entry_reg[EW-1:aws_pkg::DATA_W] == req_reg.address);
    assign has_room   = (count_reg != FULL_COUNT);

    assign sts.done     = misaligned || hit_reg || (!pend_reg && (idx_reg == count_reg));
    assign sts.out_free = !m_valid_reg || m_ready;

    // Outcome of the finished scan.
    always_comb begin
        rsp_next.read_data = '0;
        rsp_next.status    = aws_pkg::STAT_OK;
        mem_we             = 1'b0;
        mem_waddr          = hit_idx_reg;
        count_inc          = 1'b0;
        if (misaligned) begin
            rsp_next.status = aws_pkg::STAT_MISALIGNED;
        end else if (req_reg.req_type == aws_pkg::REQ_WRITE) begin
            if (hit_reg) begin
                mem_we = cmd.commit;
            end else if (has_room) begin
                mem_we    = cmd.commit;
                mem_waddr = count_reg[IW-1:0];
                count_inc = cmd.commit;
            end else begin
                rsp_next.status = aws_pkg::STAT_FULL;
            end
        end else begin
            if (hit_reg) begin
                rsp_next.read_data = hit_word_reg;
            end else begin
                rsp_next.status = aws_pkg::STAT_NOT_FOUND;
            end
        end
    end

    // Memory: one write port, one registered read port at the scan index.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_waddr] <= {req_reg.address, req_reg.write_data};
        end
        if (can_issue) begin
            rd_entry_reg <= mem_array[idx_reg[IW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_data;
        end
        if (can_issue) begin
            pend_idx_reg <= idx_reg[IW-1:0];
        end
        if (tag_match) begin
            hit_idx_reg  <= pend_idx_reg;
            hit_word_reg <= rd_entry_reg[aws_pkg::DATA_W-1:0];
        end
        if (cmd.commit) begin
            m_data_reg <= rsp_next;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (count_inc) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end else begin
                pend_reg <= can_issue;
                if (can_issue) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (tag_match) begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/associative_word_store.sv
// ----------------------------------------------------------------------------
// associative_word_store: fully associative sparse word memory
// A misaligned request, or any request while the store is empty, has its
// outcome known as soon as its scan starts; any other request scans the
// filled entries up to the first tag match or the fill count.
// Requests are taken one at a time; the tag scan reads one entry per cycle
// through the single memory read port, and a finished request waits until
// the result register can take its result word.
// Reset (aresetn low, synchronous) empties the store and the result register.
// ----------------------------------------------------------------------------
module associative_word_store #(
    parameter int ENTRIES = aws_pkg::ENTRIES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aws_pkg::aws_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output aws_pkg::aws_rsp_t m_data
);

    // The store keeps each entry as an address tag plus a data word in one
    // memory. Because writes always claim the lowest free entry and entries
    // are never released, the valid entries are exactly those below the fill
    // count, so no per-entry valid flags are kept and reset needs no clearing
    // pass.
    //
    // For each request the controller starts a scan that reads one entry per
    // cycle and compares its tag with the request address in the next cycle.
    // The scan stops at the first match or at the fill count. A write then
    // updates the matching entry or, with room left, appends a new entry at the
    // fill count; a read returns the matching word. The result word goes to an
    // output register, so a new request is taken while the previous result
    // still waits for the consumer.

    aws_pkg::aws_cmd_t cmd;
    aws_pkg::aws_sts_t sts;

    aws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aws_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
